FILE: sv/swfp_pkg.sv
package swfp_pkg;

  // Frame buffer geometry
  localparam int BufDepth = 32;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int LenW     = $clog2(BufDepth + 1);

  // Weight and decimal accumulator widths
  localparam int WeightW = 28;
  localparam int AccW    = 30;
  localparam logic [AccW-1:0] WeightMax = AccW'(99999999);

  // Frame format codes
  typedef logic [1:0] proto_t;
  localparam proto_t ProtoEqKg = 2'd0;
  localparam proto_t ProtoStx  = 2'd1;
  localparam proto_t ProtoRev  = 2'd2;

  // Characters
  localparam logic [7:0] ChStx   = 8'h02;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [31:0] KgTag  = 32'h286B_6729; // "(kg)"

  // Work handed from the front to the back
  typedef struct packed {
    logic            parse;
    proto_t          proto;
    logic [LenW-1:0] len;
  } job_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {ChSpace, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

endpackage

FILE: sv/swfp_ram.sv
module swfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/swfp_jobq.sv
module swfp_jobq import swfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rp_q];

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/swfp_front.sv
module swfp_front import swfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  proto_t           proto_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             parse_done_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output job_t             q_job_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o
);

  logic [LenW-1:0]  fill_q, fill_d;
  logic [7:0]       first_q;
  logic [23:0]      tail_q;
  logic             pend_q, pend_d;
  logic             accept, active, parse, clr;
  logic [AddrW-1:0] idx;
  logic [LenW-1:0]  len;
  logic [7:0]       first_b;
  logic [31:0]      tag;

  // Hold off while the job queue is full or a frame is being decoded out of the buffer
  assign in_stall_o = q_full_i || pend_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Append position, wrapping on a full buffer
  always_comb begin
    idx     = (fill_q >= LenW'(BufDepth)) ? '0 : fill_q[AddrW-1:0];
    len     = LenW'(idx) + LenW'(1);
    first_b = (idx == '0) ? rx_byte_i : first_q;
    tag     = {tail_q, rx_byte_i};
  end

  // Frame end detection and overflow clearing per format
  always_comb begin
    active = 1'b1;
    parse  = 1'b0;
    clr    = 1'b0;
    case (proto_i)
      ProtoEqKg: begin
        parse = (len >= LenW'(14)) && (tag == KgTag);
        clr   = (len > LenW'(29));
      end
      ProtoStx: begin
        parse = (len >= LenW'(12)) && (first_b == ChStx);
        clr   = (len >= LenW'(30));
      end
      ProtoRev: begin
        parse = (len == LenW'(8)) && (first_b == ChEq);
        clr   = (len > LenW'(9));
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    pend_d = pend_q;
    if (accept && active) begin
      fill_d = (parse || clr) ? '0 : len;
      if (parse) pend_d = 1'b1;
    end
    if (parse_done_i) pend_d = 1'b0;
  end

  assign q_push_o       = accept;
  assign q_job_o.parse  = active && parse;
  assign q_job_o.proto  = proto_i;
  assign q_job_o.len    = len;
  assign ram_we_o       = accept && active;
  assign ram_waddr_o    = idx;
  assign ram_wdata_o    = rx_byte_i;

  // Shadow copies of the first and latest bytes
  always_ff @(posedge clk_i) begin
    if (accept && active) begin
      tail_q <= tag[23:0];
      if (idx == '0) first_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: sv/swfp_back.sv
module swfp_back import swfp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  job_t                      q_job_i,
  output logic                      q_pop_o,
  output logic                      parse_done_o,
  output logic                      ram_re_o,
  output logic [AddrW-1:0]          ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [WeightW-1:0] weight_o,
  output logic                      frame_done_o
);

  typedef enum logic [1:0] {StIdle, StRun, StFin} state_e;
  typedef enum logic [2:0] {ScSeek, ScWs, ScDig, ScTail, ScBad} scan_e;

  state_e                     state_q, state_d;
  scan_e                      sc_q, sc_d;
  proto_t                     proto_q, proto_d;
  logic [LenW-1:0]            cnt_q, cnt_d, iss_q, iss_d, k_q, k_d;
  logic [AddrW-1:0]           addr_q, addr_d;
  logic                       rev_q, rev_d, rd_vld_q, rd_vld_d;
  logic [AccW-1:0]            acc_q, acc_d, prev_q, prev_d;
  logic                       neg_q, neg_d, oneg_q, oneg_d, nd_q, nd_d;
  logic                       eqf_q, eqf_d, skip_q, skip_d;
  logic signed [WeightW-1:0]  held_q, held_d, weight_q, weight_d;
  logic                       out_vld_q, out_vld_d, fd_q, fd_d;
  logic                       slot_free, issue, dec_en, ok, rneg;
  logic [7:0]                 c;
  logic [AccW-1:0]            mag;
  logic signed [WeightW-1:0]  res;

  assign c         = ram_rdata_i;
  assign slot_free = !out_vld_q || !out_stall_i;
  assign issue     = (state_q == StRun) && (iss_q < cnt_q);

  // Final value of a decoded frame
  always_comb begin
    if (proto_q == ProtoStx) begin
      mag  = prev_q;
      rneg = neg_q ^ oneg_q;
      ok   = nd_q && ((sc_q == ScDig) || (sc_q == ScTail));
    end else begin
      mag  = (acc_q > WeightMax) ? WeightMax : acc_q;
      rneg = neg_q;
      ok   = (proto_q == ProtoEqKg) ? eqf_q : 1'b1;
    end
    res = rneg ? -$signed(WeightW'(mag)) : $signed(WeightW'(mag));
  end

  // Format 1: a leading sign character is taken apart from the seven digits
  always_comb begin
    dec_en = 1'b1;
    if (proto_q == ProtoStx) begin
      if (k_q == '0) begin
        dec_en = !(c == ChMinus || c == ChPlus || c == ChSpace);
      end else if (k_q == LenW'(7)) begin
        dec_en = skip_q;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    sc_d      = sc_q;
    proto_d   = proto_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    k_d       = k_q;
    addr_d    = addr_q;
    rev_d     = rev_q;
    acc_d     = acc_q;
    prev_d    = prev_q;
    neg_d     = neg_q;
    oneg_d    = oneg_q;
    nd_d      = nd_q;
    eqf_d     = eqf_q;
    skip_d    = skip_q;
    held_d    = held_q;
    weight_d  = weight_q;
    fd_d      = fd_q;
    out_vld_d = out_vld_q;
    rd_vld_d  = issue;
    q_pop_o   = 1'b0;
    parse_done_o = 1'b0;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    // Sequential buffer reads
    if (issue) begin
      addr_d = rev_q ? addr_q - AddrW'(1) : addr_q + AddrW'(1);
      iss_d  = iss_q + LenW'(1);
    end

    case (state_q)
      StIdle: begin
        if (!q_empty_i && slot_free) begin
          q_pop_o = 1'b1;
          if (q_job_i.parse) begin
            state_d = StRun;
            proto_d = q_job_i.proto;
            case (q_job_i.proto)
              ProtoEqKg: begin
                cnt_d  = q_job_i.len;
                addr_d = '0;
              end
              ProtoStx: begin
                cnt_d  = LenW'(8);
                addr_d = AddrW'(1);
              end
              default: begin
                cnt_d  = LenW'(7);
                addr_d = AddrW'(7);
              end
            endcase
            rev_d  = (q_job_i.proto == ProtoRev);
            sc_d   = (q_job_i.proto == ProtoEqKg) ? ScSeek : ScWs;
            iss_d  = '0;
            k_d    = '0;
            acc_d  = '0;
            prev_d = '0;
            neg_d  = 1'b0;
            oneg_d = 1'b0;
            nd_d   = 1'b0;
            eqf_d  = 1'b0;
            skip_d = 1'b0;
          end else begin
            out_vld_d = 1'b1;
            weight_d  = held_q;
            fd_d      = 1'b0;
          end
        end
      end
      StRun: begin
        if (rd_vld_q) begin
          k_d = k_q + LenW'(1);
          if (k_q == cnt_q - LenW'(1)) state_d = StFin;
          if (proto_q == ProtoStx && k_q == '0 && !dec_en) begin
            skip_d = 1'b1;
            oneg_d = (c == ChMinus);
          end
          // One character of the decimal reader
          if (dec_en) begin
            case (sc_q)
              ScSeek: begin
                if (c == ChEq) begin
                  eqf_d = 1'b1;
                  sc_d  = ScWs;
                end
              end
              ScWs, ScDig: begin
                if (is_digit(c)) begin
                  if (acc_q <= WeightMax) begin
                    prev_d = acc_q;
                    acc_d  = (acc_q << 3) + (acc_q << 1) + AccW'(c[3:0]);
                  end
                  nd_d = 1'b1;
                  sc_d = ScDig;
                end else if (sc_q == ScWs) begin
                  if (is_ws(c)) begin
                    sc_d = ScWs;
                  end else if (c == ChPlus || c == ChMinus) begin
                    neg_d = (c == ChMinus);
                    sc_d  = ScDig;
                  end else begin
                    sc_d = ScBad;
                  end
                end else begin
                  sc_d = is_ws(c) ? ScTail : ScBad;
                end
              end
              ScTail: begin
                if (!is_ws(c)) sc_d = ScBad;
              end
              default: begin
                sc_d = ScBad;
              end
            endcase
          end
        end
      end
      StFin: begin
        if (slot_free) begin
          out_vld_d    = 1'b1;
          weight_d     = ok ? res : held_q;
          fd_d         = ok;
          if (ok) held_d = res;
          parse_done_o = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign ram_re_o     = issue;
  assign ram_raddr_o  = addr_q;
  assign out_valid_o  = out_vld_q;
  assign weight_o     = weight_q;
  assign frame_done_o = fd_q;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    proto_q  <= proto_d;
    cnt_q    <= cnt_d;
    iss_q    <= iss_d;
    k_q      <= k_d;
    addr_q   <= addr_d;
    rev_q    <= rev_d;
    acc_q    <= acc_d;
    prev_q   <= prev_d;
    neg_q    <= neg_d;
    oneg_q   <= oneg_d;
    nd_q     <= nd_d;
    eqf_q    <= eqf_d;
    skip_q   <= skip_d;
    sc_q     <= sc_d;
    weight_q <= weight_d;
    fd_q     <= fd_d;
  end

  // Control state, held weight and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_vld_q  <= 1'b0;
      held_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      held_q    <= held_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

FILE: sv/scale_weight_frame_parser.sv
// Weight frame parser for the serial byte stream of a weighing indicator.
// Input channel: in_valid_i / in_stall_o with rx_byte_i, one byte per
// transaction. Output channel: out_valid_o / out_stall_i with weight_o and
// frame_done_o, exactly one transaction per input byte, in order.
// protocol_select_we_i / protocol_select_i set the frame format (0 equals-kg,
// 1 STX plus seven digits, 2 reversed equals); write it only while idle.
// A byte that does not end a frame passes from the front into a two-entry
// queue that decouples the two parts, and the back registers its result,
// so such bytes can follow back to back while out_stall_i is low.
// A byte that ends a frame makes the back read the buffer RAM one byte per
// cycle: len bytes for format 0 (len up to 30 bytes), eight for format 1
// and seven for format 2; input stays stalled until that result is issued.
// Reset clears the fill count, the held weight, the queue and the format
// (format 0); buffer contents are not cleared and are only read once
// written. When out_stall_i is held, the result stays in the output
// register, the queue fills and the input stalls; nothing is dropped.
module scale_weight_frame_parser import swfp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      protocol_select_we_i,
  input  logic [1:0]                protocol_select_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [WeightW-1:0] weight_o,
  output logic                      frame_done_o
);

  proto_t           proto_q;
  logic             parse_done, q_full, q_push, q_empty, q_pop;
  job_t             q_in, q_out;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= ProtoEqKg;
    end else if (protocol_select_we_i) begin
      proto_q <= protocol_select_i;
    end
  end

  swfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .proto_i      (proto_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .parse_done_i (parse_done),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (q_in),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  swfp_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_out)
  );

  swfp_ram #(
    .Width (8),
    .Depth (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  swfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (q_out),
    .q_pop_o      (q_pop),
    .parse_done_o (parse_done),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .weight_o     (weight_o),
    .frame_done_o (frame_done_o)
  );

endmodule
